>>> rtl/series_fit_metrics_defines.svh
// Assertion macros shared by the series fit metrics RTL.
`ifndef SERIES_FIT_METRICS_DEFINES_SVH
`define SERIES_FIT_METRICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sfm_pkg.sv
// Shared types and constants for the series fit metrics block.
`default_nettype none
package sfm_pkg;

  localparam int SFM_MAX_SAMPLES = 4096;
  localparam int SFM_XW = 24;   // sample width
  localparam int SFM_NW = 13;   // pair count
  localparam int SFM_SW = 36;   // plain sums
  localparam int SFM_QW = 59;   // sums of squares
  localparam int SFM_CW = 60;   // cross sum
  localparam int SFM_EW = 62;   // squared error sum
  localparam int SFM_MW = 76;   // serial multiplier operand
  localparam int SFM_PW = 2 * SFM_MW;
  localparam int SFM_LW = 17;   // Q1.16 loss
  localparam int SFM_RW = 23;   // rmse
  localparam int SFM_QDEPTH = 2;
  localparam int SFM_QCW = $clog2(SFM_QDEPTH + 1);

  localparam logic [SFM_LW-1:0] SFM_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OBS_ZERO = 2'd1,
    ST_SIM_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Finished sums of one series.
  typedef struct packed {
    logic                     ovf;
    logic [SFM_NW-1:0]        n;
    logic signed [SFM_SW-1:0] sx;
    logic signed [SFM_SW-1:0] sy;
    logic [SFM_QW-1:0]        qx;
    logic [SFM_QW-1:0]        qy;
    logic signed [SFM_CW-1:0] c;
    logic [SFM_EW-1:0]        e;
  } snap_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } push_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } head_t;

endpackage
`default_nettype wire

>>> rtl/sfm_front.sv
// Sample intake: capacity check, product pipeline and running sums.
`default_nettype none
module sfm_front import sfm_pkg::*; #(
  parameter int MAX_SAMPLES = SFM_MAX_SAMPLES
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [2*SFM_XW-1:0]    s_axis_tdata,  // obs_sample, sim_sample
  input  wire logic                   s_axis_tlast,  // last_sample
  input  wire logic [SFM_QCW-1:0]     q_free,
  output push_t                       push
);

  localparam int CNTW = $clog2(MAX_SAMPLES + 1);

  logic [CNTW-1:0] cnt;
  logic            keep, accept;

  logic                     a_valid, a_keep, a_last;
  logic signed [SFM_XW-1:0] a_x, a_y;
  logic signed [SFM_XW:0]   a_d;

  logic                       b_valid, b_keep, b_last;
  logic signed [SFM_XW-1:0]   b_x, b_y;
  logic [2*SFM_XW-2:0]        b_xx, b_yy;
  logic signed [2*SFM_XW-1:0] b_xy;
  logic [2*SFM_XW:0]          b_dd;

  logic                     ovf;
  logic [SFM_NW-1:0]        pair_count;
  logic signed [SFM_SW-1:0] sum_observed, sum_simulated;
  logic [SFM_QW-1:0]        sum_observed_sq, sum_simulated_sq;
  logic signed [SFM_CW-1:0] sum_cross;
  logic [SFM_EW-1:0]        sum_error_sq;
  snap_t                    nxt;

  logic signed [2*SFM_XW-1:0] xx_full, yy_full, xy_full;
  logic signed [2*SFM_XW+1:0] dd_full;
  logic [SFM_QCW-1:0]         pending;

  // Hold off intake while pending series ends could overfill the queue
  assign pending = SFM_QCW'(a_valid & a_last) + SFM_QCW'(b_valid & b_last);
  assign s_axis_tready = pending < q_free;
  assign accept = s_axis_tvalid & s_axis_tready;
  assign keep = cnt < CNTW'(MAX_SAMPLES);

  // Stage A: capture pair, decide keep or drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if (s_axis_tlast) cnt <= '0;
        else if (keep) cnt <= cnt + CNTW'(1);
      end
    end
    if (accept) begin
      a_x <= s_axis_tdata[SFM_XW-1:0];
      a_y <= s_axis_tdata[2*SFM_XW-1:SFM_XW];
      a_d <= $signed({s_axis_tdata[SFM_XW-1], s_axis_tdata[SFM_XW-1:0]})
           - $signed({s_axis_tdata[2*SFM_XW-1], s_axis_tdata[2*SFM_XW-1:SFM_XW]});
      a_keep <= keep;
      a_last <= s_axis_tlast;
    end
  end

  assign xx_full = a_x * a_x;
  assign yy_full = a_y * a_y;
  assign xy_full = a_x * a_y;
  assign dd_full = a_d * a_d;

  // Stage B: register products
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else b_valid <= a_valid;
    if (a_valid) begin
      b_x <= a_x;
      b_y <= a_y;
      b_xx <= xx_full[2*SFM_XW-2:0];
      b_yy <= yy_full[2*SFM_XW-2:0];
      b_xy <= xy_full;
      b_dd <= dd_full[2*SFM_XW:0];
      b_keep <= a_keep;
      b_last <= a_last;
    end
  end

  // Next sums with this pair folded in
  always_comb begin
    nxt.ovf = ovf | ~b_keep;
    nxt.n   = pair_count;
    nxt.sx  = sum_observed;
    nxt.sy  = sum_simulated;
    nxt.qx  = sum_observed_sq;
    nxt.qy  = sum_simulated_sq;
    nxt.c   = sum_cross;
    nxt.e   = sum_error_sq;
    if (b_keep) begin
      nxt.n  = pair_count + SFM_NW'(1);
      nxt.sx = sum_observed + SFM_SW'(b_x);
      nxt.sy = sum_simulated + SFM_SW'(b_y);
      nxt.qx = sum_observed_sq + SFM_QW'(b_xx);
      nxt.qy = sum_simulated_sq + SFM_QW'(b_yy);
      nxt.c  = sum_cross + SFM_CW'(b_xy);
      nxt.e  = sum_error_sq + SFM_EW'(b_dd);
    end
  end

  // Stage C: accumulate, hand off and clear at series end
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
      pair_count <= '0;
      sum_observed <= '0;
      sum_simulated <= '0;
      sum_observed_sq <= '0;
      sum_simulated_sq <= '0;
      sum_cross <= '0;
      sum_error_sq <= '0;
    end else if (b_valid) begin
      if (b_last) begin
        ovf <= 1'b0;
        pair_count <= '0;
        sum_observed <= '0;
        sum_simulated <= '0;
        sum_observed_sq <= '0;
        sum_simulated_sq <= '0;
        sum_cross <= '0;
        sum_error_sq <= '0;
      end else begin
        ovf <= nxt.ovf;
        pair_count <= nxt.n;
        sum_observed <= nxt.sx;
        sum_simulated <= nxt.sy;
        sum_observed_sq <= nxt.qx;
        sum_simulated_sq <= nxt.qy;
        sum_cross <= nxt.c;
        sum_error_sq <= nxt.e;
      end
    end
  end

  assign push.valid = b_valid & b_last;
  assign push.snap  = nxt;

endmodule
`default_nettype wire

>>> rtl/sfm_queue.sv
// Short queue of finished series sums between intake and math engine.
`default_nettype none
module sfm_queue import sfm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire push_t              push,
  output logic [SFM_QCW-1:0]      q_free,
  output head_t                   head,
  input  wire logic               pop
);

  localparam int PW = (SFM_QDEPTH > 1) ? $clog2(SFM_QDEPTH) : 1;

  snap_t               mem [SFM_QDEPTH];
  logic [PW-1:0]       wp, rp;
  logic [SFM_QCW-1:0]  count;
  logic                do_pop;

  assign do_pop = pop & (count != '0);
  assign q_free = SFM_QCW'(SFM_QDEPTH) - count;
  assign head.valid = count != '0;
  assign head.snap = mem[rp];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push.valid) wp <= (wp == PW'(SFM_QDEPTH - 1)) ? '0 : wp + PW'(1);
      if (do_pop) rp <= (rp == PW'(SFM_QDEPTH - 1)) ? '0 : rp + PW'(1);
      count <= count + SFM_QCW'(push.valid) - SFM_QCW'(do_pop);
    end
    if (push.valid) mem[wp] <= push.snap;
  end

`include "series_fit_metrics_defines.svh"
  `SFM_ASSERT_NOW(a_no_push_full, count == SFM_QCW'(SFM_QDEPTH), !push.valid, "push into full queue")
  `SFM_ASSERT_NXT(a_count_up, push.valid && !do_pop, count == $past(count) + SFM_QCW'(1), "queue count lost a push")

endmodule
`default_nettype wire

>>> rtl/sfm_back.sv
// Math engine: serial multiplies, fraction divides, mean and root for one series.
`default_nettype none
module sfm_back import sfm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire head_t                head,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // nse_loss, r2_loss, rmse
  output logic [1:0]                m_axis_tuser   // status
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MSET  = 13'b0000000000010,
    S_MRUN  = 13'b0000000000100,
    S_MPOST = 13'b0000000001000,
    S_FSET  = 13'b0000000010000,
    S_FCHK  = 13'b0000000100000,
    S_FRUN  = 13'b0000001000000,
    S_FEND  = 13'b0000010000000,
    S_DSET  = 13'b0000100000000,
    S_DRUN  = 13'b0001000000000,
    S_SSET  = 13'b0010000000000,
    S_SRUN  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  typedef enum logic [3:0] {
    OP_NQX = 4'd0, OP_XX = 4'd1, OP_NQY = 4'd2, OP_YY = 4'd3, OP_NC = 4'd4,
    OP_XY = 4'd5, OP_NE = 4'd6, OP_DXY2 = 4'd7, OP_DEN = 4'd8
  } mop_t;

  localparam int MCW = $clog2(SFM_MW);

  state_t st;
  mop_t   op;

  // Loaded series
  logic              ovf, xneg, yneg, cneg;
  logic [SFM_NW-1:0] n;
  logic [SFM_SW-1:0] xa, ya;
  logic [SFM_QW-1:0] qx, qy;
  logic [SFM_CW-1:0] ca;
  logic [SFM_EW-1:0] e;

  // Multiplier and intermediates
  logic [MCW-1:0]    mcnt;
  logic [SFM_PW-1:0] prod;
  logic [SFM_MW-1:0] mcand, op_a, op_b, tmp, dxx, dyy, dxy, ne;
  logic [SFM_PW-1:0] num, den;
  logic [SFM_MW:0]   madd;

  // Fraction divider
  logic              fsel;
  logic [3:0]        fcnt;
  logic [SFM_PW:0]   rem, fsh;
  logic [SFM_PW-1:0] fb;
  logic [SFM_LW-1:0] fq;

  // Mean divider and root
  logic [5:0]          dcnt;
  logic [SFM_EW-1:0]   dq;
  logic [SFM_NW:0]     dr, dtrial;
  logic [4:0]          scnt;
  logic [63:0]         sx, sres, sbit, strial;

  logic [SFM_LW-1:0] nse, r2;
  logic [SFM_LW-1:0] out_nse, out_r2;
  logic [SFM_RW-1:0] rmse;
  status_t           status;

  // Operand select per multiply step
  always_comb begin
    case (op)
      OP_NQX:  begin op_a = SFM_MW'(n);  op_b = SFM_MW'(qx); end
      OP_XX:   begin op_a = SFM_MW'(xa); op_b = SFM_MW'(xa); end
      OP_NQY:  begin op_a = SFM_MW'(n);  op_b = SFM_MW'(qy); end
      OP_YY:   begin op_a = SFM_MW'(ya); op_b = SFM_MW'(ya); end
      OP_NC:   begin op_a = SFM_MW'(n);  op_b = SFM_MW'(ca); end
      OP_XY:   begin op_a = SFM_MW'(xa); op_b = SFM_MW'(ya); end
      OP_NE:   begin op_a = SFM_MW'(n);  op_b = SFM_MW'(e);  end
      OP_DXY2: begin op_a = dxy;         op_b = dxy;         end
      OP_DEN:  begin op_a = dxx;         op_b = dyy;         end
      default: begin op_a = '0;          op_b = '0;          end
    endcase
  end

  assign madd   = {1'b0, prod[SFM_PW-1:SFM_MW]} + (prod[0] ? {1'b0, mcand} : '0);
  assign fsh    = {rem[SFM_PW-1:0], 1'b0};
  assign dtrial = {dr[SFM_NW-1:0], dq[SFM_EW-1]};
  assign strial = sres + sbit;

  assign pop = (st == S_IDLE) & head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid & m_axis_tready) m_axis_tvalid <= 1'b0;
      case (st)
        // Load a series and take magnitudes
        S_IDLE: begin
          if (head.valid) begin
            ovf <= head.snap.ovf;
            n <= head.snap.n;
            xneg <= head.snap.sx[SFM_SW-1];
            yneg <= head.snap.sy[SFM_SW-1];
            cneg <= head.snap.c[SFM_CW-1];
            xa <= head.snap.sx[SFM_SW-1] ? SFM_SW'(-head.snap.sx) : head.snap.sx;
            ya <= head.snap.sy[SFM_SW-1] ? SFM_SW'(-head.snap.sy) : head.snap.sy;
            ca <= head.snap.c[SFM_CW-1] ? SFM_CW'(-head.snap.c) : head.snap.c;
            qx <= head.snap.qx;
            qy <= head.snap.qy;
            e <= head.snap.e;
            op <= OP_NQX;
            st <= S_MSET;
          end
        end
        S_MSET: begin
          prod <= {{SFM_MW{1'b0}}, op_b};
          mcand <= op_a;
          mcnt <= MCW'(SFM_MW - 1);
          st <= S_MRUN;
        end
        // One multiplier bit per cycle
        S_MRUN: begin
          prod <= {madd, prod[SFM_MW-1:1]};
          mcnt <= mcnt - MCW'(1);
          if (mcnt == '0) st <= S_MPOST;
        end
        S_MPOST: begin
          case (op)
            OP_NQX, OP_NQY, OP_NC: tmp <= prod[SFM_MW-1:0];
            OP_XX: dxx <= tmp - prod[SFM_MW-1:0];
            OP_YY: dyy <= tmp - prod[SFM_MW-1:0];
            OP_XY: begin
              if (cneg == (xneg ^ yneg))
                dxy <= (tmp >= prod[SFM_MW-1:0]) ? tmp - prod[SFM_MW-1:0]
                                                 : prod[SFM_MW-1:0] - tmp;
              else
                dxy <= tmp + prod[SFM_MW-1:0];
            end
            OP_NE: ne <= prod[SFM_MW-1:0];
            OP_DXY2: num <= prod;
            OP_DEN: den <= prod;
            default: tmp <= tmp;
          endcase
          if (op == OP_DEN) begin
            fsel <= 1'b0;
            st <= S_FSET;
          end else begin
            op <= mop_t'(op + 4'd1);
            st <= S_MSET;
          end
        end
        // Set up a fraction, saturate on zero variance
        S_FSET: begin
          if (!fsel) begin
            if (dxx == '0) begin
              nse <= SFM_ONE;
              r2 <= SFM_ONE;
              st <= S_DSET;
            end else begin
              rem <= {{(SFM_MW + 1){1'b0}}, ne};
              fb <= {{SFM_MW{1'b0}}, dxx};
              st <= S_FCHK;
            end
          end else begin
            if (dyy == '0) begin
              r2 <= SFM_ONE;
              st <= S_DSET;
            end else begin
              rem <= {1'b0, num};
              fb <= den;
              st <= S_FCHK;
            end
          end
          fq <= '0;
          fcnt <= '0;
        end
        S_FCHK: begin
          if (rem >= {1'b0, fb}) begin
            fq <= SFM_ONE;
            st <= S_FEND;
          end else begin
            st <= S_FRUN;
          end
        end
        // One quotient bit per cycle
        S_FRUN: begin
          if (fsh >= {1'b0, fb}) begin
            rem <= fsh - {1'b0, fb};
            fq <= {fq[SFM_LW-2:0], 1'b1};
          end else begin
            rem <= fsh;
            fq <= {fq[SFM_LW-2:0], 1'b0};
          end
          fcnt <= fcnt + 4'd1;
          if (fcnt == 4'd15) st <= S_FEND;
        end
        S_FEND: begin
          if (!fsel) begin
            nse <= fq;
            fsel <= 1'b1;
            st <= S_FSET;
          end else begin
            r2 <= SFM_ONE - fq;
            st <= S_DSET;
          end
        end
        // Mean squared error: E / N
        S_DSET: begin
          dr <= '0;
          dcnt <= '0;
          if (n == '0) begin
            dq <= '0;
            st <= S_SSET;
          end else begin
            dq <= e;
            st <= S_DRUN;
          end
        end
        S_DRUN: begin
          if (dtrial >= {1'b0, n}) begin
            dr <= dtrial - {1'b0, n};
            dq <= {dq[SFM_EW-2:0], 1'b1};
          end else begin
            dr <= dtrial;
            dq <= {dq[SFM_EW-2:0], 1'b0};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(SFM_EW - 1)) st <= S_SSET;
        end
        // Integer square root, two radicand bits per cycle
        S_SSET: begin
          sx <= 64'(dq);
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
          scnt <= '0;
          st <= S_SRUN;
        end
        S_SRUN: begin
          if (sx >= strial) begin
            sx <= sx - strial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) st <= S_DONE;
        end
        // Present result once the output register is free
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_nse <= nse;
            out_r2 <= r2;
            rmse <= (sres[63:SFM_RW] != '0) ? {SFM_RW{1'b1}} : sres[SFM_RW-1:0];
            if (ovf) status <= ST_OVERFLOW;
            else if (dxx == '0) status <= ST_OBS_ZERO;
            else if (dyy == '0) status <= ST_SIM_ZERO;
            else status <= ST_OK;
            m_axis_tvalid <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, rmse, out_r2, out_nse};
  assign m_axis_tuser = status;

`include "series_fit_metrics_defines.svh"
  `SFM_ASSERT_NOW(a_obs_zero_sat, m_axis_tvalid && status == ST_OBS_ZERO, out_nse == SFM_ONE && out_r2 == SFM_ONE, "zero observed variance not saturated")
  `SFM_ASSERT_NOW(a_loss_range, $rose(m_axis_tvalid), out_nse <= SFM_ONE && out_r2 <= SFM_ONE, "loss above one")

endmodule
`default_nettype wire

>>> rtl/series_fit_metrics.sv
// Top level of the series fit metrics block: intake, queue and math engine.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata: obs_sample[23:0], sim_sample[47:24]; tlast: last_sample
//  m_axis    out  tdata: nse_loss[16:0], r2_loss[33:17], rmse[56:34]; tuser: status
//
//  Intake takes one sample pair per cycle while s_axis_tready is high; a beat
//  passes the stage A and stage B registers before it is added to the sums, and
//  a finished series enters the queue as its last beat is added. For each series
//  the engine runs nine serial multiplies, up to two fraction divides, a mean
//  divide and a square root in turn. A two-entry queue holds finished series;
//  intake stalls when the queue cannot take the series ends already in flight.
//  Reset is synchronous and clears all control state and the running sums.
`default_nettype none
module series_fit_metrics import sfm_pkg::*; #(
  parameter int MAX_SAMPLES = SFM_MAX_SAMPLES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [2*SFM_XW-1:0] s_axis_tdata,  // obs_sample, sim_sample
  input  wire logic                s_axis_tlast,  // last_sample
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [63:0]              m_axis_tdata,  // nse_loss, r2_loss, rmse
  output logic [1:0]               m_axis_tuser   // status
);

  push_t              push;
  head_t              head;
  logic [SFM_QCW-1:0] q_free;
  logic               pop;

  sfm_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .q_free(q_free), .push(push)
  );

  sfm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .q_free(q_free), .head(head), .pop(pop)
  );

  sfm_back u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule
`default_nettype wire
